FILE: src/ddpf_pkg.sv
// ----------------------------------------------------------------------------
// ddpf_pkg
// Shared widths, codes and pipeline types for the damped dispersion pair
// force unit.
// ----------------------------------------------------------------------------
package ddpf_pkg;

  localparam int TYPE_W  = 4;
  localparam int SEL_W   = 3;
  localparam int COEF_W  = 48;
  localparam int RSQ_W   = 32;
  localparam int FAC_W   = 16;

  localparam int SQ_W    = 64;   // rsq^2
  localparam int R6_W    = 60;   // rsq^3 >> 36
  localparam int UD_W    = 61;   // clamped denominator
  localparam int DSQ_W   = 122;  // denominator squared
  localparam int FX_W    = 121;  // force numerator
  localparam int EX_W    = 72;   // energy numerator
  localparam int QUO_W   = 63;   // quotient bits kept by both dividers

  localparam logic KIND_EVAL = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam logic [SEL_W-1:0] SEL_CUTOFF = 3'd0;
  localparam logic [SEL_W-1:0] SEL_DAMP   = 3'd1;
  localparam logic [SEL_W-1:0] SEL_FCOEF  = 3'd2;
  localparam logic [SEL_W-1:0] SEL_ECOEF  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_OFFSET = 3'd4;

  localparam logic [QUO_W-1:0]  T_LIMIT   = 63'h7FFF_0000_0000_0000;
  localparam logic [COEF_W-1:0] NEG_LIMIT = 48'h8000_0000_0000;
  localparam logic [COEF_W-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic              hit;
    logic              fpos;
    logic              eneg;
    logic [COEF_W-1:0] off;
    logic [FAC_W-1:0]  fac;
  } tag_t;

  typedef struct packed {
    tag_t tag;
    logic fovf;
    logic eovf;
  } side_t;

  typedef struct packed {
    logic [COEF_W-1:0] force_val;
    logic [COEF_W-1:0] energy_val;
    logic              cut_hit;
    logic              sat;
  } res_t;

endpackage

FILE: src/ddpf_divider.sv
// ----------------------------------------------------------------------------
// ddpf_divider
// Pipelined restoring divider, one quotient bit per stage. Expects
// num < den * 2^Q_W; the caller flags the other case itself.
// ----------------------------------------------------------------------------
module ddpf_divider #(
  parameter int NUM_W = 72,
  parameter int DEN_W = 61,
  parameter int Q_W   = 63
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quot
);

  logic [DEN_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   low_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [Q_W-1:0]   low_in;
    logic [Q_W-1:0]   q_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic             take;

    if (s == 0) begin : g_first
      assign rem_in = DEN_W'(num[NUM_W-1:Q_W]);
      assign low_in = num[Q_W-1:0];
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign low_in = low_r[s-1];
      assign q_in   = q_r[s-1];
      assign den_in = den_r[s-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial = {rem_in, low_in[Q_W-1]};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        low_r[s] <= {low_in[Q_W-2:0], 1'b0};
        q_r[s]   <= {q_in[Q_W-2:0], take};
        den_r[s] <= den_in;
      end
    end
  end

  assign quot = q_r[Q_W-1];

endmodule

FILE: src/damped_dispersion_pair_force_unit.sv
// ----------------------------------------------------------------------------
// damped_dispersion_pair_force_unit
// Becke-Johnson damped dispersion pair evaluator with per-type-pair tables.
//
// Input channel (in_valid/in_ready): one word per pair or table load. A load
// word (kind 1) writes one coefficient at the edge it is taken and gives no
// result. An evaluate word (kind 0) gives one result word on the output
// channel (out_valid/out_ready): force over r, energy, cutoff flag and
// saturation flag, in input order.
// Throughput is one word per cycle while the output queue has room. An
// accepted word passes 8 stages of table read, multiplies and denominator
// squaring, 63 stages of the two pipelined dividers (one quotient bit per
// stage), then 2 stages of clipping and scaling, then a 2-word output queue.
// The whole pipeline advances while the output queue has room; when the
// receiver stalls the queue fills and in_ready drops, nothing is dropped.
// in_ready depends only on registered state.
// Reset clears the valid bits and the queue; table contents are kept and
// must be written before an entry is used.
// ----------------------------------------------------------------------------
module damped_dispersion_pair_force_unit
  import ddpf_pkg::*;
#(
  parameter int TYPE_COUNT = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     kind,
  input  logic [TYPE_W-1:0]        type_a,
  input  logic [TYPE_W-1:0]        type_b,
  input  logic [SEL_W-1:0]         coef_select,
  input  logic signed [COEF_W-1:0] coef_value,
  input  logic [RSQ_W-1:0]         squared_distance,
  input  logic [FAC_W-1:0]         special_factor,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [COEF_W-1:0] force_over_r,
  output logic signed [COEF_W-1:0] pair_energy,
  output logic                     within_cutoff,
  output logic                     saturated
);

  localparam int DEPTH  = TYPE_COUNT * (2 ** TYPE_W);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [TYPE_W:0] TYPE_LIM = TYPE_COUNT[TYPE_W:0];

  logic en;
  logic acc;

  // ---------------- tables ----------------
  logic [COEF_W-1:0] cut_mem  [DEPTH];
  logic [COEF_W-1:0] damp_mem [DEPTH];
  logic [COEF_W-1:0] fc_mem   [DEPTH];
  logic [COEF_W-1:0] ec_mem   [DEPTH];
  logic [COEF_W-1:0] off_mem  [DEPTH];

  logic [2*TYPE_W-1:0] idx_full;
  logic [ADDR_W-1:0]   addr;
  logic                type_ok;

  assign acc      = in_valid && in_ready;
  assign idx_full = {type_a, type_b};
  assign addr     = idx_full[ADDR_W-1:0];
  assign type_ok  = ({1'b0, type_a} < TYPE_LIM) && ({1'b0, type_b} < TYPE_LIM);

  always_ff @(posedge clk) begin
    if (acc && kind == KIND_LOAD && type_ok) begin
      unique case (coef_select)
        SEL_CUTOFF: cut_mem[addr]  <= coef_value;
        SEL_DAMP:   damp_mem[addr] <= coef_value;
        SEL_FCOEF:  fc_mem[addr]   <= coef_value;
        SEL_ECOEF:  ec_mem[addr]   <= coef_value;
        SEL_OFFSET: off_mem[addr]  <= coef_value;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: table read ----------------
  logic              v1, s1_tok;
  logic [RSQ_W-1:0]  s1_rsq;
  logic [FAC_W-1:0]  s1_fac;
  logic [COEF_W-1:0] s1_cut, s1_damp, s1_fc, s1_ec, s1_off;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tok  <= type_ok;
      s1_rsq  <= squared_distance;
      s1_fac  <= special_factor;
      s1_cut  <= cut_mem[addr];
      s1_damp <= damp_mem[addr];
      s1_fc   <= fc_mem[addr];
      s1_ec   <= ec_mem[addr];
      s1_off  <= off_mem[addr];
    end
  end

  // ---------------- stage 2: cutoff, rsq^2, |fcoef|*factor ----------------
  logic              v2;
  tag_t              s2_tag;
  logic [RSQ_W-1:0]  s2_rsq;
  logic [SQ_W-1:0]   s2_sq2, s2_ff;
  logic [COEF_W-1:0] s2_em, s2_damp;
  logic [COEF_W-1:0] fm1, em1;
  tag_t              tag1;

  always_comb begin
    fm1 = s1_fc[COEF_W-1] ? COEF_W'(48'd0 - s1_fc) : s1_fc;
    em1 = s1_ec[COEF_W-1] ? COEF_W'(48'd0 - s1_ec) : s1_ec;
    tag1.hit  = s1_tok && !s1_cut[COEF_W-1] && ({12'd0, s1_rsq, 4'd0} < s1_cut);
    tag1.fpos = !s1_fc[COEF_W-1] && (s1_fc != '0);
    tag1.eneg = s1_ec[COEF_W-1];
    tag1.off  = s1_off;
    tag1.fac  = s1_fac;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag  <= tag1;
      s2_rsq  <= s1_rsq;
      s2_sq2  <= {32'd0, s1_rsq} * {32'd0, s1_rsq};
      s2_ff   <= {16'd0, fm1} * {48'd0, s1_fac};
      s2_em   <= em1;
      s2_damp <= s1_damp;
    end
  end

  // ---------------- stage 3: partial products ----------------
  logic              v3;
  tag_t              s3_tag;
  logic [63:0]       s3_plo, s3_phi, s3_p00, s3_p01, s3_p10, s3_p11;
  logic [COEF_W-1:0] s3_em, s3_damp;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tag  <= s2_tag;
      s3_plo  <= {32'd0, s2_sq2[31:0]}  * {32'd0, s2_rsq};
      s3_phi  <= {32'd0, s2_sq2[63:32]} * {32'd0, s2_rsq};
      s3_p00  <= {32'd0, s2_ff[31:0]}  * {32'd0, s2_sq2[31:0]};
      s3_p01  <= {32'd0, s2_ff[31:0]}  * {32'd0, s2_sq2[63:32]};
      s3_p10  <= {32'd0, s2_ff[63:32]} * {32'd0, s2_sq2[31:0]};
      s3_p11  <= {32'd0, s2_ff[63:32]} * {32'd0, s2_sq2[63:32]};
      s3_em   <= s2_em;
      s3_damp <= s2_damp;
    end
  end

  // ---------------- stage 4: r^6 and force numerator ----------------
  logic              v4;
  tag_t              s4_tag;
  logic [R6_W-1:0]   s4_r6;
  logic [FX_W-1:0]   s4_fx;
  logic [COEF_W-1:0] s4_em, s4_damp;
  logic [95:0]       cube;
  logic [127:0]      fprod;

  assign cube  = {s3_phi, 32'd0} + {32'd0, s3_plo};
  assign fprod = {s3_p11, 64'd0} + {32'd0, s3_p01, 32'd0}
               + {32'd0, s3_p10, 32'd0} + {64'd0, s3_p00};

  always_ff @(posedge clk) begin
    if (en) begin
      s4_tag  <= s3_tag;
      s4_r6   <= cube[95:36];
      s4_fx   <= fprod[127:7];
      s4_em   <= s3_em;
      s4_damp <= s3_damp;
    end
  end

  // ---------------- stage 5: damped denominator ----------------
  logic              v5;
  tag_t              s5_tag;
  logic [UD_W-1:0]   s5_ud;
  logic [FX_W-1:0]   s5_fx;
  logic [COEF_W-1:0] s5_em;
  logic [61:0]       dsum;

  assign dsum = {2'b00, s4_r6} + {{14{s4_damp[COEF_W-1]}}, s4_damp};

  always_ff @(posedge clk) begin
    if (en) begin
      s5_tag <= s4_tag;
      // zero or negative denominator counts as one lsb
      s5_ud  <= (dsum[61] || dsum == '0) ? UD_W'(1) : dsum[UD_W-1:0];
      s5_fx  <= s4_fx;
      s5_em  <= s4_em;
    end
  end

  // ---------------- stage 6: square partials, energy overflow ----------------
  logic              v6;
  tag_t              s6_tag;
  logic [63:0]       s6_q00;
  logic [60:0]       s6_q01;
  logic [57:0]       s6_q11;
  logic [FX_W-1:0]   s6_fx;
  logic [COEF_W-1:0] s6_em;
  logic [UD_W-1:0]   s6_ud;
  logic              s6_eovf;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tag  <= s5_tag;
      s6_q00  <= {32'd0, s5_ud[31:0]} * {32'd0, s5_ud[31:0]};
      s6_q01  <= {29'd0, s5_ud[31:0]} * {32'd0, s5_ud[60:32]};
      s6_q11  <= {29'd0, s5_ud[60:32]} * {29'd0, s5_ud[60:32]};
      s6_fx   <= s5_fx;
      s6_em   <= s5_em;
      s6_ud   <= s5_ud;
      // quotient of em*2^24 by ud reaches 2^63
      s6_eovf <= ({52'd0, s5_em[47:39]} >= s5_ud);
    end
  end

  // ---------------- stage 7: denominator squared ----------------
  logic              v7;
  tag_t              s7_tag;
  logic [DSQ_W-1:0]  s7_dsq;
  logic [FX_W-1:0]   s7_fx;
  logic [COEF_W-1:0] s7_em;
  logic [UD_W-1:0]   s7_ud;
  logic              s7_eovf;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_tag  <= s6_tag;
      s7_dsq  <= {s6_q11, 64'd0} + {28'd0, s6_q01, 33'd0} + {58'd0, s6_q00};
      s7_fx   <= s6_fx;
      s7_em   <= s6_em;
      s7_ud   <= s6_ud;
      s7_eovf <= s6_eovf;
    end
  end

  // ---------------- stage 8: force overflow, divider operands ----------------
  logic              v8;
  side_t             s8_side;
  logic [FX_W-1:0]   s8_fx;
  logic [DSQ_W-1:0]  s8_dsq;
  logic [EX_W-1:0]   s8_ex;
  logic [UD_W-1:0]   s8_ud;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_side.tag  <= s7_tag;
      s8_side.fovf <= ({64'd0, s7_fx[FX_W-1:QUO_W]} >= s7_dsq);
      s8_side.eovf <= s7_eovf;
      s8_fx        <= s7_fx;
      s8_dsq       <= s7_dsq;
      s8_ex        <= {s7_em, 24'd0};
      s8_ud        <= s7_ud;
    end
  end

  // ---------------- dividers ----------------
  logic [QUO_W-1:0] fq, eq;

  ddpf_divider #(.NUM_W(FX_W), .DEN_W(DSQ_W), .Q_W(QUO_W)) u_fdiv (
    .clk  (clk),
    .en   (en),
    .num  (s8_fx),
    .den  (s8_dsq),
    .quot (fq)
  );

  ddpf_divider #(.NUM_W(EX_W), .DEN_W(UD_W), .Q_W(QUO_W)) u_ediv (
    .clk  (clk),
    .en   (en),
    .num  (s8_ex),
    .den  (s8_ud),
    .quot (eq)
  );

  side_t            side_line [QUO_W];
  logic [QUO_W-1:0] vline;

  always_ff @(posedge clk) begin
    if (en) begin
      side_line[0] <= s8_side;
      for (int i = 1; i < QUO_W; i++) begin
        side_line[i] <= side_line[i-1];
      end
    end
  end

  // ---------------- stage A: force clip, energy phi ----------------
  logic              vA;
  logic              sA_hit, sA_fsat;
  logic [COEF_W-1:0] sA_fres;
  logic [63:0]       sA_ph;
  logic [FAC_W-1:0]  sA_fac;
  side_t             sd;
  logic [COEF_W-1:0] flimit, fmag;
  logic              fsat;
  logic [QUO_W-1:0]  tq;

  always_comb begin
    sd     = side_line[QUO_W-1];
    flimit = sd.tag.fpos ? NEG_LIMIT : POS_LIMIT;
    fsat   = sd.fovf || (fq > {15'd0, flimit});
    fmag   = fsat ? flimit : fq[COEF_W-1:0];
    tq     = (sd.eovf || eq > T_LIMIT) ? T_LIMIT : eq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sA_hit  <= sd.tag.hit;
      sA_fsat <= fsat;
      sA_fres <= sd.tag.fpos ? COEF_W'(48'd0 - fmag) : fmag;
      // phi = -t - offset, with t carrying the sign of the energy coefficient
      sA_ph   <= (sd.tag.eneg ? {1'b0, tq} : 64'd0 - {1'b0, tq})
               - {{16{sd.tag.off[COEF_W-1]}}, sd.tag.off};
      sA_fac  <= sd.tag.fac;
    end
  end

  // ---------------- stage B: energy scaling ----------------
  logic              vB;
  logic              sB_hit, sB_fsat, sB_pneg;
  logic [COEF_W-1:0] sB_fres;
  logic [78:0]       sB_prod;
  logic [63:0]       phm;

  assign phm = sA_ph[63] ? 64'd0 - sA_ph : sA_ph;

  always_ff @(posedge clk) begin
    if (en) begin
      sB_hit  <= sA_hit;
      sB_fsat <= sA_fsat;
      sB_pneg <= sA_ph[63];
      sB_fres <= sA_fres;
      sB_prod <= {16'd0, phm[62:0]} * {63'd0, sA_fac};
    end
  end

  // ---------------- stage C: energy clip, result word ----------------
  logic [63:0]       ex_s;
  logic [COEF_W-1:0] elimit, emag, eres;
  logic              esat;
  res_t              res;

  always_comb begin
    ex_s   = sB_prod[78:15];
    elimit = sB_pneg ? NEG_LIMIT : POS_LIMIT;
    esat   = ex_s > {16'd0, elimit};
    emag   = esat ? elimit : ex_s[COEF_W-1:0];
    eres   = sB_pneg ? COEF_W'(48'd0 - emag) : emag;
    res.force_val  = sB_hit ? sB_fres : '0;
    res.energy_val = sB_hit ? eres : '0;
    res.cut_hit    = sB_hit;
    res.sat        = sB_hit && (sB_fsat || esat);
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
      vline <= '0;
      vA    <= 1'b0;
      vB    <= 1'b0;
    end else if (en) begin
      v1    <= acc && kind == KIND_EVAL;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      v6    <= v5;
      v7    <= v6;
      v8    <= v7;
      vline <= {vline[QUO_W-2:0], v8};
      vA    <= vline[QUO_W-1];
      vB    <= vA;
    end
  end

  // ---------------- output queue ----------------
  res_t       head, tail;
  logic [1:0] count;
  logic       push, pop;

  assign en        = (count != 2'd2);
  assign in_ready  = en;
  assign push      = vB && en;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          head <= res;
        end else begin
          tail <= res;
        end
      end
      2'b01: head <= tail;
      2'b11: head <= res;
      default: ;
    endcase
  end

  assign force_over_r  = head.force_val;
  assign pair_energy   = head.energy_val;
  assign within_cutoff = head.cut_hit;
  assign saturated     = head.sat;

endmodule
